[hw/rtl/tlpt_pkg.sv]
// shared types and constants of the lift position tracker
package tlpt_pkg;

    localparam int PRESET_SLOTS = 512;
    localparam int SLOT_AW      = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
    localparam int SLOT_W       = 9;
    localparam int POS_W        = 31;
    localparam int TIME_W       = 32;
    localparam int TRIM_W       = 16;
    localparam int OP_W         = 3;
    localparam int DRV_W        = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_UP     = 3'd0,
        OP_DOWN   = 3'd1,
        OP_STOP   = 3'd2,
        OP_GET    = 3'd3,
        OP_INVOKE = 3'd4,
        OP_SET    = 3'd5
    } t_op;

    typedef enum logic [DRV_W-1:0] {
        DRV_STOP = 2'd0,
        DRV_UP   = 2'd1,
        DRV_DOWN = 2'd2
    } t_drive;

    // previous command code: zero for none, else op plus one
    localparam logic [OP_W-1:0] PREV_NONE = 3'd0;
    localparam logic [OP_W-1:0] PREV_UP   = 3'd1;
    localparam logic [OP_W-1:0] PREV_DOWN = 3'd2;
    localparam logic [OP_W-1:0] PREV_STOP = 3'd3;

    typedef struct packed {
        t_op                op;
        logic [TIME_W-1:0]  now;
        logic [SLOT_AW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        logic clearing;
    } t_bk_status;

    typedef struct packed {
        t_drive            drive;
        logic [POS_W-1:0]  hold;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_res;

endpackage

[hw/rtl/tlpt_ram.sv]
// generic single write port ram with registered read
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tlpt_front.sv]
// command intake: accepts items, drops illegal ones, feeds the queue
module tlpt_front (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tlpt_pkg::OP_W-1:0]     i_op,
    input  logic [tlpt_pkg::TIME_W-1:0]   i_now,
    input  logic [tlpt_pkg::SLOT_W-1:0]   i_slot,
    input  logic                          i_q_full,
    input  tlpt_pkg::t_bk_status          i_status,
    output tlpt_pkg::t_push               o_push
);

    logic w_op_ok;
    logic w_slot_ok;
    logic w_accept;

    always_comb begin
        w_op_ok   = (i_op <= tlpt_pkg::OP_SET);
        w_slot_ok = 1'b1;
        if (i_op inside {tlpt_pkg::OP_INVOKE, tlpt_pkg::OP_SET}) begin
            w_slot_ok = (32'(i_slot) < 32'(tlpt_pkg::PRESET_SLOTS));
        end
    end

    // no intake while the queue is full or the preset store is being cleared
    assign o_stall  = i_q_full | i_status.clearing;
    assign w_accept = i_valid & ~o_stall;

    assign o_push.valid    = w_accept & w_op_ok & w_slot_ok;
    assign o_push.cmd.op   = tlpt_pkg::t_op'(i_op);
    assign o_push.cmd.now  = i_now;
    assign o_push.cmd.addr = tlpt_pkg::SLOT_AW'(i_slot);

endmodule

[hw/rtl/tlpt_queue.sv]
// short command queue between intake and execution
module tlpt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlpt_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_full,
    output tlpt_pkg::t_qhead o_head
);

    localparam int QAW = (tlpt_pkg::QUEUE_DEPTH > 1) ? $clog2(tlpt_pkg::QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(tlpt_pkg::QUEUE_DEPTH + 1);

    tlpt_pkg::t_cmd r_slot [tlpt_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_do_pop;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        ptr_inc = (p == QAW'(tlpt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full      = (r_count == CW'(tlpt_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rptr];
    assign w_do_pop     = i_pop & o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_slot[r_wptr] <= i_push.cmd;
                r_wptr         <= ptr_inc(r_wptr);
            end
            if (w_do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push.valid && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/tlpt_back.sv]
// command execution: position bookkeeping, preset store, result output
module tlpt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tlpt_pkg::TRIM_W-1:0]   i_cfg_wdata,
    input  tlpt_pkg::t_qhead              i_head,
    output logic                          o_pop,
    output tlpt_pkg::t_bk_status          o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tlpt_pkg::DRV_W-1:0]    o_drive_code,
    output logic [tlpt_pkg::POS_W-1:0]    o_hold_ticks,
    output logic [tlpt_pkg::POS_W-1:0]    o_position,
    output logic                          o_last
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_INV,
        S_EMIT
    } t_state;

    localparam int PW = tlpt_pkg::POS_W;
    localparam int TW = tlpt_pkg::TIME_W;
    localparam int AW = tlpt_pkg::SLOT_AW;

    t_state                     r_state;
    logic [tlpt_pkg::TRIM_W-1:0] r_trim;
    logic [PW-1:0]              r_pos;
    logic [TW-1:0]              r_start;
    logic [tlpt_pkg::OP_W-1:0]  r_prev;
    logic [AW-1:0]              r_clr_addr;
    tlpt_pkg::t_cmd             r_cmd;
    logic [TW-1:0]              r_elapsed;
    logic [PW-1:0]              r_tgt;
    logic [PW-1:0]              r_dist;
    logic                       r_down;
    logic                       r_neq;
    tlpt_pkg::t_res             r_res0;
    tlpt_pkg::t_res             r_res1;
    logic                       r_out_valid;
    tlpt_pkg::t_res             r_out;

    logic                       w_out_free;
    logic                       w_emit;
    logic [TW:0]                w_sum;
    logic [PW-1:0]              w_add_sat;
    logic [PW-1:0]              w_sub_floor;
    logic [PW-1:0]              w_booked;
    logic                       w_prev_move;
    logic [tlpt_pkg::OP_W-1:0]  w_same;
    logic [PW-1:0]              w_ram_rdata;
    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [PW-1:0]              w_ram_wdata;
    logic [PW-1:0]              w_hold;
    tlpt_pkg::t_drive           w_move_drv;

    // booking of travel since the last move, saturating both ways; also the new move's drive and the invoke hold time
    always_comb begin
        w_sum       = (TW+1)'(r_pos) + (TW+1)'(r_elapsed);
        w_add_sat   = (w_sum[TW:PW] != '0) ? tlpt_pkg::POS_MAX : w_sum[PW-1:0];
        w_sub_floor = (r_elapsed >= TW'(r_pos)) ? '0 : r_pos - r_elapsed[PW-1:0];
        w_prev_move = (r_prev == tlpt_pkg::PREV_UP) || (r_prev == tlpt_pkg::PREV_DOWN);
        w_booked    = (r_prev == tlpt_pkg::PREV_DOWN) ? w_add_sat : w_sub_floor;
        w_same      = tlpt_pkg::OP_W'(r_cmd.op) + 1'b1;
        w_move_drv  = (r_cmd.op == tlpt_pkg::OP_UP) ? tlpt_pkg::DRV_UP : tlpt_pkg::DRV_DOWN;
        w_hold      = (r_dist > PW'(r_trim)) ? r_dist - PW'(r_trim) : '0;
    end

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_cmd.addr;
        w_ram_wdata = r_pos;
        if (r_state == S_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = '0;
        end else if (r_state == S_EXEC && r_cmd.op == tlpt_pkg::OP_SET
                     && r_prev == tlpt_pkg::PREV_STOP) begin
            w_ram_we = 1'b1;
        end
    end

    tlpt_ram #(
        .WIDTH (PW),
        .DEPTH (tlpt_pkg::PRESET_SLOTS)
    ) u_preset_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (i_head.cmd.addr),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free      = ~r_out_valid | ~i_out_stall;
    assign w_emit          = (r_state == S_EMIT) & w_out_free;
    assign o_pop           = (r_state == S_IDLE) & i_head.valid;
    assign o_status.clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_trim      <= '0;
            r_pos       <= '0;
            r_start     <= '0;
            r_prev      <= tlpt_pkg::PREV_NONE;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_trim <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(tlpt_pkg::PRESET_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd     <= i_head.cmd;
                        r_elapsed <= i_head.cmd.now - r_start;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_prev  <= w_same;
                    case (r_cmd.op)
                        tlpt_pkg::OP_UP, tlpt_pkg::OP_DOWN: begin
                            if (r_prev != w_same) begin
                                r_start <= r_cmd.now;
                                r_state <= S_EMIT;
                                if (w_prev_move) begin
                                    // reversal: stop with booked travel, then new move
                                    r_pos  <= w_booked;
                                    r_res0 <= '{tlpt_pkg::DRV_STOP, '0, w_booked, 1'b0};
                                    r_res1 <= '{w_move_drv, '0, w_booked, 1'b1};
                                end else begin
                                    r_res0 <= '{w_move_drv, '0, r_pos, 1'b1};
                                    r_res1 <= '{w_move_drv, '0, r_pos, 1'b1};
                                end
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        tlpt_pkg::OP_STOP: begin
                            r_state <= S_EMIT;
                            if (w_prev_move) begin
                                r_pos  <= w_booked;
                                r_res0 <= '{tlpt_pkg::DRV_STOP, '0, w_booked, 1'b1};
                            end else begin
                                r_res0 <= '{tlpt_pkg::DRV_STOP, '0, r_pos, 1'b1};
                            end
                        end
                        tlpt_pkg::OP_INVOKE: begin
                            r_tgt   <= w_ram_rdata;
                            r_down  <= (w_ram_rdata > r_pos);
                            r_neq   <= (w_ram_rdata != r_pos);
                            r_dist  <= (w_ram_rdata > r_pos) ? w_ram_rdata - r_pos
                                                             : r_pos - w_ram_rdata;
                            r_state <= S_INV;
                        end
                        default: begin
                            // get and set give no result
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_INV: begin
                    r_pos   <= r_tgt;
                    r_state <= S_EMIT;
                    if (r_neq) begin
                        r_start <= r_cmd.now;
                        r_res0  <= '{r_down ? tlpt_pkg::DRV_DOWN : tlpt_pkg::DRV_UP,
                                     w_hold, r_pos, 1'b0};
                        r_res1  <= '{tlpt_pkg::DRV_STOP, '0, r_tgt, 1'b1};
                    end else begin
                        r_res0  <= '{tlpt_pkg::DRV_STOP, '0, r_tgt, 1'b1};
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out <= r_res0;
                        if (r_res0.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_res0 <= r_res1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive_code = r_out.drive;
    assign o_hold_ticks = r_out.hold;
    assign o_position   = r_out.pos;
    assign o_last       = r_out.last;

endmodule

[hw/rtl/timed_lift_position_tracker.sv]
// top level of the dead-reckoning lift position tracker
//
// Commands (up, down, stop, get, invoke preset, set preset) enter on the input
// channel with a 32-bit tick timestamp and a preset slot; each gives zero, one
// or two drive frames on the output channel, the final one flagged by o_last.
// Position is the accumulated travel time, clamped at zero and saturating at
// 2^31-1. Intake checks and drops illegal items (unknown op, slot beyond the
// preset store) and places the rest in a two-entry queue, so items keep coming
// in while the execution side works. Execution picks up an item and starts the
// preset memory read, then acts on it; for an invoke it then works out the hold
// time after trim. Results then go one at a time into the output register, which
// holds a stalled result. After reset the preset store is cleared one slot a
// cycle, with o_in_stall high; the trim register may be written then.
module timed_lift_position_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // trim register
    input  logic                          i_cfg_we,
    input  logic [tlpt_pkg::TRIM_W-1:0]   i_cfg_wdata,
    // command items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tlpt_pkg::OP_W-1:0]     i_op,
    input  logic [tlpt_pkg::TIME_W-1:0]   i_now,
    input  logic [tlpt_pkg::SLOT_W-1:0]   i_slot,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tlpt_pkg::DRV_W-1:0]    o_drive_code,
    output logic [tlpt_pkg::POS_W-1:0]    o_hold_ticks,
    output logic [tlpt_pkg::POS_W-1:0]    o_position,
    output logic                          o_last
);

    tlpt_pkg::t_push      w_push;
    tlpt_pkg::t_qhead     w_head;
    tlpt_pkg::t_bk_status w_status;
    logic                 w_q_full;
    logic                 w_pop;

    // intake and classification
    tlpt_front u_front (
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_op     (i_op),
        .i_now    (i_now),
        .i_slot   (i_slot),
        .i_q_full (w_q_full),
        .i_status (w_status),
        .o_push   (w_push)
    );

    // decouples intake from execution
    tlpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    // bookkeeping, preset store and output register
    tlpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_drive_code (o_drive_code),
        .o_hold_ticks (o_hold_ticks),
        .o_position   (o_position),
        .o_last       (o_last)
    );

endmodule

[hw/rtl/tlpt_checker.sv]
// port-level checks of the lift position tracker, bound to the top level
module tlpt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [tlpt_pkg::TRIM_W-1:0]   i_cfg_wdata,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [tlpt_pkg::OP_W-1:0]     i_op,
    input logic [tlpt_pkg::TIME_W-1:0]   i_now,
    input logic [tlpt_pkg::SLOT_W-1:0]   i_slot,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tlpt_pkg::DRV_W-1:0]    o_drive_code,
    input logic [tlpt_pkg::POS_W-1:0]    o_hold_ticks,
    input logic [tlpt_pkg::POS_W-1:0]    o_position,
    input logic                          o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_drive_code)
            && $stable(o_hold_ticks) && $stable(o_position) && $stable(o_last)))
        else $error("stalled result changed");

    // only the move of an invoke carries a hold time, and a stop follows it
    a_hold_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hold_ticks != '0) |->
            (!o_last && o_drive_code != tlpt_pkg::DRV_STOP))
        else $error("hold time on a wrong result");

    // preset clear runs right after reset, with intake stalled
    a_clear_stall: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("intake open during preset clear");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind timed_lift_position_tracker tlpt_checker u_tlpt_checker (.*);
